/* sv/lmws_pkg.sv */
// Shared types, widths and helpers for the sliding local map cube block.
// Used by every module of local_map_window_slide; depends on nothing.
package lmws_pkg;

  localparam int CoordW    = 32;
  localparam int EdgeW     = 31;
  localparam int FactW     = 16;
  localparam int ProdW     = EdgeW + FactW;
  localparam int FactShift = 8;
  localparam int ThW       = ProdW - FactShift;
  localparam int MovW      = 42;
  localparam int ANumW     = ProdW + 3;
  localparam int A9W       = ANumW + 4;
  localparam int MovShift  = 10;
  localparam int WideW     = A9W - MovShift;
  localparam int DivBy     = 5;
  localparam int IdxW      = 2;
  localparam int NumAxes   = 3;
  localparam int AxisW     = $clog2(NumAxes);
  localparam int FifoDepth = 2;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int FillW     = $clog2(FifoDepth + 1);

  localparam logic [IdxW-1:0] RegEdge   = 2'd0;
  localparam logic [IdxW-1:0] RegRange  = 2'd1;
  localparam logic [IdxW-1:0] RegFactor = 2'd2;

  localparam logic [EdgeW-1:0] EdgeReset   = 31'd65536000;
  localparam logic [EdgeW-1:0] RangeReset  = 31'd6553600;
  localparam logic [FactW-1:0] FactorReset = 16'd384;

  localparam logic KindSlab = 1'b0;
  localparam logic KindCube = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t [NumAxes-1:0] lo;
    coord_t [NumAxes-1:0] hi;
  } box_t;

  typedef struct packed {
    logic [NumAxes-1:0] shift;
    logic [NumAxes-1:0] lo_side;
    box_t               old_box;
    box_t               new_box;
  } entry_t;

  typedef struct packed {
    logic                   busy;
    logic [ThW-1:0]         thresh;
    logic signed [MovW-1:0] mov;
    logic [EdgeW-1:0]       edge_len;
  } prm_t;

  typedef struct packed {
    logic kind;
    box_t box;
    logic last;
  } result_t;

  function automatic coord_t sat32(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi_lim;
    logic signed [WideW-1:0] lo_lim;
    hi_lim = {{(WideW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}};
    lo_lim = {{(WideW-CoordW+1){1'b1}}, {(CoordW-1){1'b0}}};
    if (v > hi_lim) begin
      return hi_lim[CoordW-1:0];
    end else if (v < lo_lim) begin
      return lo_lim[CoordW-1:0];
    end
    return v[CoordW-1:0];
  endfunction

endpackage

/* sv/lmws_prm.sv */
// Configuration registers and the sequencer that derives the move threshold
// and move distance from them. Depends on lmws_pkg.
module lmws_prm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lmws_pkg::IdxW-1:0]   cfg_idx_i,
  input  logic [lmws_pkg::EdgeW-1:0]  cfg_wdata_i,
  output lmws_pkg::prm_t              prm_o
);

  typedef enum logic [3:0] {
    S_MUL, S_SUB, S_MUL9, S_ABS, S_EST0, S_EST1, S_EST2, S_REM, S_FIX, S_FIN, S_MAX,
    S_DONE
  } state_e;

  state_e                               state_q;
  logic [lmws_pkg::EdgeW-1:0]           edge_q;
  logic [lmws_pkg::EdgeW-1:0]           range_q;
  logic [lmws_pkg::FactW-1:0]           factor_q;
  logic [lmws_pkg::ProdW-1:0]           prod_q;
  logic [lmws_pkg::ThW-1:0]             thresh_q;
  logic signed [lmws_pkg::MovW-1:0]     bmov_q;
  logic signed [lmws_pkg::ANumW-1:0]    anum_q;
  logic signed [lmws_pkg::WideW-1:0]    x_q;
  logic                                 neg_q;
  logic [lmws_pkg::WideW-1:0]           mag_q;
  logic [lmws_pkg::WideW-1:0]           quot_q;
  logic [5:0]                           rem6_q;
  logic [2:0]                           rem_q;
  logic signed [lmws_pkg::MovW-1:0]     amov_q;
  logic signed [lmws_pkg::MovW-1:0]     mov_q;

  logic [lmws_pkg::ProdW-1:0]           prod_d;
  logic signed [lmws_pkg::MovW-1:0]     bmov_d;
  logic signed [lmws_pkg::ANumW-1:0]    anum_d;
  logic signed [lmws_pkg::A9W-1:0]      a9_w;
  logic signed [lmws_pkg::WideW-1:0]    x_d;
  logic [lmws_pkg::WideW-1:0]           mag_d;
  logic [lmws_pkg::WideW-1:0]           est0_w;
  logic [lmws_pkg::WideW-1:0]           est1_w;
  logic [lmws_pkg::WideW-1:0]           est2_w;
  logic [lmws_pkg::WideW-1:0]           est3_w;
  logic [lmws_pkg::WideW-1:0]           est4_w;
  logic [lmws_pkg::WideW-1:0]           five_w;
  logic [lmws_pkg::WideW-1:0]           diff_w;
  logic [9:0]                           fix_w;
  logic [3:0]                           corr_w;
  logic [5:0]                           left_w;
  logic [2:0]                           rem_d;
  logic signed [lmws_pkg::MovW-1:0]     amov_d;
  logic signed [lmws_pkg::MovW-1:0]     mov_d;

  assign prod_d = lmws_pkg::ProdW'(factor_q) * lmws_pkg::ProdW'(range_q);
  assign bmov_d = $signed(lmws_pkg::MovW'(prod_q[lmws_pkg::ProdW-1:lmws_pkg::FactShift]))
                - $signed(lmws_pkg::MovW'(range_q));
  assign anum_d = $signed(lmws_pkg::ANumW'({edge_q, 8'b0}))
                - $signed(lmws_pkg::ANumW'({prod_q, 1'b0}));
  assign a9_w   = ($signed(lmws_pkg::A9W'(anum_q)) <<< 3) + $signed(lmws_pkg::A9W'(anum_q));
  assign x_d    = $signed(a9_w[lmws_pkg::A9W-1:lmws_pkg::MovShift]);
  assign mag_d  = x_q[lmws_pkg::WideW-1] ? lmws_pkg::WideW'(-x_q) : lmws_pkg::WideW'(x_q);

  // The shift-add estimate of mag / 5 is never high and at most six low, so
  // the small remainder left over corrects it exactly.
  assign est0_w = (mag_q >> 3) + (mag_q >> 4);
  assign est1_w = est0_w + (est0_w >> 4);
  assign est2_w = quot_q + (quot_q >> 8);
  assign est3_w = est2_w + (est2_w >> 16);
  assign est4_w = quot_q + (quot_q >> 32);
  assign five_w = (quot_q << 2) + quot_q;
  assign diff_w = mag_q - five_w;
  assign fix_w  = 10'(rem6_q) * 10'd13;
  assign corr_w = fix_w[9:6];
  assign left_w = rem6_q - 6'(corr_w) * 6'(lmws_pkg::DivBy);
  assign rem_d  = left_w[2:0];

  assign amov_d = neg_q
                ? -$signed(lmws_pkg::MovW'(quot_q) + lmws_pkg::MovW'(rem_q != 3'd0))
                : $signed(lmws_pkg::MovW'(quot_q));
  assign mov_d  = (amov_q > bmov_q) ? amov_q : bmov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_MUL;
      edge_q   <= lmws_pkg::EdgeReset;
      range_q  <= lmws_pkg::RangeReset;
      factor_q <= lmws_pkg::FactorReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lmws_pkg::RegEdge:   edge_q   <= cfg_wdata_i;
        lmws_pkg::RegRange:  range_q  <= cfg_wdata_i;
        lmws_pkg::RegFactor: factor_q <= cfg_wdata_i[lmws_pkg::FactW-1:0];
        default: ;
      endcase
      state_q <= S_MUL;
    end else begin
      case (state_q)
        S_MUL: begin
          prod_q  <= prod_d;
          state_q <= S_SUB;
        end
        S_SUB: begin
          thresh_q <= prod_q[lmws_pkg::ProdW-1:lmws_pkg::FactShift];
          bmov_q   <= bmov_d;
          anum_q   <= anum_d;
          state_q  <= S_MUL9;
        end
        S_MUL9: begin
          x_q     <= x_d;
          state_q <= S_ABS;
        end
        S_ABS: begin
          neg_q   <= x_q[lmws_pkg::WideW-1];
          mag_q   <= mag_d;
          state_q <= S_EST0;
        end
        S_EST0: begin
          quot_q  <= est1_w;
          state_q <= S_EST1;
        end
        S_EST1: begin
          quot_q  <= est3_w;
          state_q <= S_EST2;
        end
        S_EST2: begin
          quot_q  <= est4_w;
          state_q <= S_REM;
        end
        S_REM: begin
          rem6_q  <= diff_w[5:0];
          state_q <= S_FIX;
        end
        S_FIX: begin
          quot_q  <= quot_q + lmws_pkg::WideW'(corr_w);
          rem_q   <= rem_d;
          state_q <= S_FIN;
        end
        S_FIN: begin
          amov_q  <= amov_d;
          state_q <= S_MAX;
        end
        S_MAX: begin
          mov_q   <= mov_d;
          state_q <= S_DONE;
        end
        default: state_q <= S_DONE;
      endcase
    end
  end

  assign prm_o.busy     = state_q != S_DONE;
  assign prm_o.thresh   = thresh_q;
  assign prm_o.mov      = mov_q;
  assign prm_o.edge_len = edge_q;

endmodule

/* sv/lmws_front.sv */
// Input side: accepts positions, holds the cube, decides which faces are near
// and writes one work entry per position. Depends on lmws_pkg.
module lmws_front (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  lmws_pkg::coord_t [lmws_pkg::NumAxes-1:0]  pos_i,
  input  lmws_pkg::prm_t                            prm_i,
  input  logic                                      full_i,
  output logic                                      push_o,
  output lmws_pkg::entry_t                          entry_o
);

  logic          cube_valid_q;
  lmws_pkg::box_t cube_q;

  logic signed [lmws_pkg::WideW-1:0] th_w;
  logic signed [lmws_pkg::WideW-1:0] mv_w;
  logic signed [lmws_pkg::WideW-1:0] half_w;
  logic signed [lmws_pkg::WideW-1:0] edge_w;

  assign th_w   = $signed(lmws_pkg::WideW'(prm_i.thresh));
  assign mv_w   = lmws_pkg::WideW'($signed(prm_i.mov));
  assign half_w = $signed(lmws_pkg::WideW'(prm_i.edge_len >> 1));
  assign edge_w = $signed(lmws_pkg::WideW'(prm_i.edge_len));

  always_comb begin
    logic signed [lmws_pkg::WideW-1:0] p;
    logic signed [lmws_pkg::WideW-1:0] clo;
    logic signed [lmws_pkg::WideW-1:0] chi;
    logic signed [lmws_pkg::WideW-1:0] dlo;
    logic signed [lmws_pkg::WideW-1:0] dhi;
    logic                              near_lo;
    logic                              near_hi;
    entry_o.old_box = cube_q;
    entry_o.new_box = cube_q;
    entry_o.shift   = '0;
    entry_o.lo_side = '0;
    for (int a = 0; a < lmws_pkg::NumAxes; a++) begin
      p       = lmws_pkg::WideW'($signed(pos_i[a]));
      clo     = lmws_pkg::WideW'($signed(cube_q.lo[a]));
      chi     = lmws_pkg::WideW'($signed(cube_q.hi[a]));
      dlo     = p - clo;
      dhi     = p - chi;
      near_lo = (dlo <= th_w) && (dlo >= -th_w);
      near_hi = (dhi <= th_w) && (dhi >= -th_w);
      if (!cube_valid_q) begin
        entry_o.new_box.lo[a] = lmws_pkg::sat32(p - half_w);
        entry_o.new_box.hi[a] = lmws_pkg::sat32(p - half_w + edge_w);
      end else if (near_lo) begin
        entry_o.shift[a]      = 1'b1;
        entry_o.lo_side[a]    = 1'b1;
        entry_o.new_box.lo[a] = lmws_pkg::sat32(clo - mv_w);
        entry_o.new_box.hi[a] = lmws_pkg::sat32(chi - mv_w);
      end else if (near_hi) begin
        entry_o.shift[a]      = 1'b1;
        entry_o.new_box.lo[a] = lmws_pkg::sat32(clo + mv_w);
        entry_o.new_box.hi[a] = lmws_pkg::sat32(chi + mv_w);
      end
    end
  end

  assign in_ready_o = !prm_i.busy && !full_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cube_valid_q <= 1'b0;
    end else if (push_o) begin
      cube_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_o) begin
      cube_q <= entry_o.new_box;
    end
  end

endmodule

/* sv/lmws_fifo.sv */
// Short queue of work entries between the input side and the output side.
// Depends on lmws_pkg.
module lmws_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lmws_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output lmws_pkg::entry_t entry_o,
  output logic             empty_o
);

  lmws_pkg::entry_t            mem_q [lmws_pkg::FifoDepth];
  logic [lmws_pkg::PtrW-1:0]   wr_ptr_q;
  logic [lmws_pkg::PtrW-1:0]   rd_ptr_q;
  logic [lmws_pkg::FillW-1:0]  fill_q;

  assign full_o  = fill_q == lmws_pkg::FillW'(lmws_pkg::FifoDepth);
  assign empty_o = fill_q == '0;
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* sv/lmws_back.sv */
// Output side: turns a work entry into its removal slabs and the current cube,
// one result per cycle unless stalled, via an output register; needs lmws_pkg.
module lmws_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lmws_pkg::entry_t  entry_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lmws_pkg::result_t result_o
);

  lmws_pkg::entry_t             cur_q;
  logic                         cur_valid_q;
  logic [lmws_pkg::NumAxes-1:0] pend_q;
  logic                         out_valid_q;
  lmws_pkg::result_t            res_q;

  logic                         adv_w;
  logic                         emit_w;
  logic                         finish_w;
  logic [lmws_pkg::AxisW-1:0]   sel_w;
  logic [lmws_pkg::NumAxes-1:0] pend_d;
  lmws_pkg::box_t               slab_w;
  lmws_pkg::result_t            res_d;

  assign adv_w    = !out_valid_q || out_ready_i;
  assign emit_w   = adv_w && cur_valid_q;
  assign finish_w = emit_w && (pend_q == '0);
  assign pop_o    = (!cur_valid_q || finish_w) && !empty_i;

  always_comb begin
    sel_w = '0;
    for (int a = lmws_pkg::NumAxes - 1; a >= 0; a--) begin
      if (pend_q[a]) begin
        sel_w = lmws_pkg::AxisW'(a);
      end
    end
    pend_d        = pend_q;
    pend_d[sel_w] = 1'b0;
    slab_w        = cur_q.old_box;
    if (cur_q.lo_side[sel_w]) begin
      slab_w.lo[sel_w] = cur_q.new_box.hi[sel_w];
    end else begin
      slab_w.hi[sel_w] = cur_q.new_box.lo[sel_w];
    end
    if (pend_q != '0) begin
      res_d.kind = lmws_pkg::KindSlab;
      res_d.box  = slab_w;
      res_d.last = 1'b0;
    end else begin
      res_d.kind = lmws_pkg::KindCube;
      res_d.box  = cur_q.new_box;
      res_d.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_valid_q <= 1'b1;
        pend_q      <= entry_i.shift;
      end else if (finish_w) begin
        cur_valid_q <= 1'b0;
      end else if (emit_w) begin
        pend_q <= pend_d;
      end
      if (adv_w) begin
        out_valid_q <= cur_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
    end
    if (emit_w) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

/* sv/local_map_window_slide.sv */
// Sliding local map cube: keeps an axis-aligned map cube around the sensor
// position and reports removal slabs and the cube. Depends on lmws_pkg and on
// lmws_prm, lmws_front, lmws_fifo and lmws_back.
//
// Each accepted position yields one to four results on the output channel,
// one result per cycle while out_ready_i is high: a slab for every axis on
// which the cube moves, in x, y, z order, and then the cube itself with last
// set. Positions are accepted back to back while the two-entry work queue
// has room. After reset and after every configuration write the block
// computes the move threshold and move distance in a sequence of states,
// part of which divides by five with shifts and adds; in_ready_o stays low
// during that sequence. Coordinates are Q16.16 and saturate.
module local_map_window_slide (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lmws_pkg::IdxW-1:0]   cfg_idx_i,
  input  logic [lmws_pkg::EdgeW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [31:0]          pos_x_i,
  input  logic signed [31:0]          pos_y_i,
  input  logic signed [31:0]          pos_z_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        kind_o,
  output logic signed [31:0]          box_min_x_o,
  output logic signed [31:0]          box_min_y_o,
  output logic signed [31:0]          box_min_z_o,
  output logic signed [31:0]          box_max_x_o,
  output logic signed [31:0]          box_max_y_o,
  output logic signed [31:0]          box_max_z_o,
  output logic                        last_o
);

  lmws_pkg::prm_t                           prm_w;
  lmws_pkg::coord_t [lmws_pkg::NumAxes-1:0] pos_w;
  lmws_pkg::entry_t                         push_entry_w;
  lmws_pkg::entry_t                         head_entry_w;
  logic                                     push_w;
  logic                                     pop_w;
  logic                                     full_w;
  logic                                     empty_w;
  lmws_pkg::result_t                        result_w;

  assign pos_w[0] = pos_x_i;
  assign pos_w[1] = pos_y_i;
  assign pos_w[2] = pos_z_i;

  lmws_prm u_prm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .prm_o       (prm_w)
  );

  lmws_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pos_i      (pos_w),
    .prm_i      (prm_w),
    .full_i     (full_w),
    .push_o     (push_w),
    .entry_o    (push_entry_w)
  );

  lmws_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .entry_i (push_entry_w),
    .full_o  (full_w),
    .pop_i   (pop_w),
    .entry_o (head_entry_w),
    .empty_o (empty_w)
  );

  lmws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry_w),
    .empty_i     (empty_w),
    .pop_o       (pop_w),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_w)
  );

  assign kind_o      = result_w.kind;
  assign box_min_x_o = result_w.box.lo[0];
  assign box_min_y_o = result_w.box.lo[1];
  assign box_min_z_o = result_w.box.lo[2];
  assign box_max_x_o = result_w.box.hi[0];
  assign box_max_y_o = result_w.box.hi[1];
  assign box_max_z_o = result_w.box.hi[2];
  assign last_o      = result_w.last;

endmodule

/* bench/local_map_window_slide_tb.sv */
// Self-checking testbench for local_map_window_slide, the sliding local map cube.
// Holds a cube predictor and slab scoreboard and drives both handshake channels.
// Depends on lmws_pkg and the local_map_window_slide RTL.
module local_map_window_slide_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint MovDen    = 5120;
  localparam int     RecalcGap = 60;

  typedef struct packed {
    logic            kind;
    logic [2:0][31:0] lo;
    logic [2:0][31:0] hi;
    logic            last;
  } box_beat_t;

  class cube_scoreboard;
    longint    cube_lo[3];
    longint    cube_hi[3];
    bit        placed;
    longint    edge_size;
    longint    sense_range;
    longint    mv_factor;
    box_beat_t expected_boxes[$];
    int        errors;
    int        beats;
    int        slabs_seen;
    int        cubes_seen;
    int        positions;

    function new();
      int i;
      for (i = 0; i < 3; i++) begin
        cube_lo[i] = 0;
        cube_hi[i] = 0;
      end
      placed      = 1'b0;
      edge_size   = lmws_pkg::EdgeReset;
      sense_range = lmws_pkg::RangeReset;
      mv_factor   = lmws_pkg::FactorReset;
    endfunction

    function void set_reg(logic [lmws_pkg::IdxW-1:0] idx, logic [lmws_pkg::EdgeW-1:0] value);
      case (idx)
        lmws_pkg::RegEdge: begin
          edge_size = value;
        end
        lmws_pkg::RegRange: begin
          sense_range = value;
        end
        lmws_pkg::RegFactor: begin
          mv_factor = value[lmws_pkg::FactW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int pending();
      return expected_boxes.size();
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function longint near_limit();
      return (mv_factor * sense_range) >> 8;
    endfunction

    function longint move_dist();
      longint a_num;
      longint b_num;
      longint num;
      longint q;
      a_num = (edge_size * 256 - 2 * mv_factor * sense_range) * 9;
      b_num = sense_range * (mv_factor - 256) * 20;
      num   = (a_num > b_num) ? a_num : b_num;
      q     = num / MovDen;
      if ((num % MovDen) != 0 && num < 0) q--;
      return q;
    endfunction

    function void push_box(logic kind, longint lo[3], longint hi[3], logic last);
      box_beat_t b;
      int i;
      b.kind = kind;
      b.last = last;
      for (i = 0; i < 3; i++) begin
        b.lo[i] = 32'(lo[i]);
        b.hi[i] = 32'(hi[i]);
      end
      expected_boxes.insert(expected_boxes.size(), b);
    endfunction

    function void note_position(lmws_pkg::coord_t px, lmws_pkg::coord_t py,
                                lmws_pkg::coord_t pz);
      longint p[3];
      longint nlo[3];
      longint nhi[3];
      longint slo[3];
      longint shi[3];
      longint th;
      longint mv;
      longint half;
      bit     near_lo;
      bit     near_hi;
      int     i;
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      positions++;
      if (!placed) begin
        half = edge_size / 2;
        for (i = 0; i < 3; i++) begin
          cube_lo[i] = clamp32(p[i] - half);
          cube_hi[i] = clamp32(p[i] - half + edge_size);
        end
        placed = 1'b1;
        push_box(lmws_pkg::KindCube, cube_lo, cube_hi, 1'b1);
        return;
      end
      th  = near_limit();
      mv  = move_dist();
      nlo = cube_lo;
      nhi = cube_hi;
      for (i = 0; i < 3; i++) begin
        near_lo = mag(p[i] - cube_lo[i]) <= th;
        near_hi = mag(p[i] - cube_hi[i]) <= th;
        if (near_lo || near_hi) begin
          slo = cube_lo;
          shi = cube_hi;
          // The min face takes precedence when both faces are close.
          if (near_lo) begin
            nlo[i] = clamp32(cube_lo[i] - mv);
            nhi[i] = clamp32(cube_hi[i] - mv);
            slo[i] = clamp32(cube_hi[i] - mv);
          end else begin
            nlo[i] = clamp32(cube_lo[i] + mv);
            nhi[i] = clamp32(cube_hi[i] + mv);
            shi[i] = clamp32(cube_lo[i] + mv);
          end
          push_box(lmws_pkg::KindSlab, slo, shi, 1'b0);
        end
      end
      cube_lo = nlo;
      cube_hi = nhi;
      push_box(lmws_pkg::KindCube, cube_lo, cube_hi, 1'b1);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_box(box_beat_t got);
      box_beat_t want;
      string     axn;
      int        i;
      axn = "xyz";
      beats++;
      if (expected_boxes.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing expected (kind %0d)", beats, got.kind));
        return;
      end
      want = expected_boxes.pop_front();
      if (got.kind != want.kind)
        report($sformatf("beat %0d kind: expected %0d, got %0d", beats, want.kind, got.kind));
      for (i = 0; i < 3; i++) begin
        if (got.lo[i] !== want.lo[i])
          report($sformatf("beat %0d box_min_%c: expected %0d, got %0d", beats, axn[i],
                           $signed(want.lo[i]), $signed(got.lo[i])));
        if (got.hi[i] !== want.hi[i])
          report($sformatf("beat %0d box_max_%c: expected %0d, got %0d", beats, axn[i],
                           $signed(want.hi[i]), $signed(got.hi[i])));
      end
      if (got.last !== want.last)
        report($sformatf("beat %0d last: expected %0d, got %0d", beats, want.last, got.last));
      if (want.kind == lmws_pkg::KindCube) cubes_seen++;
      else slabs_seen++;
    endtask
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [lmws_pkg::IdxW-1:0]   cfg_idx_i;
  logic [lmws_pkg::EdgeW-1:0]  cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic signed [31:0]          pos_x_i;
  logic signed [31:0]          pos_y_i;
  logic signed [31:0]          pos_z_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic                        kind_o;
  logic signed [31:0]          box_min_x_o;
  logic signed [31:0]          box_min_y_o;
  logic signed [31:0]          box_min_z_o;
  logic signed [31:0]          box_max_x_o;
  logic signed [31:0]          box_max_y_o;
  logic signed [31:0]          box_max_z_o;
  logic                        last_o;

  cube_scoreboard board;
  bit             gaps_on;
  int             settings;

  local_map_window_slide dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .box_min_x_o(box_min_x_o),
    .box_min_y_o(box_min_y_o),
    .box_min_z_o(box_min_z_o),
    .box_max_x_o(box_max_x_o),
    .box_max_y_o(box_max_y_o),
    .box_max_z_o(box_max_z_o),
    .last_o     (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (gaps_on && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    box_beat_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind = kind_o;
      got.lo   = {box_min_z_o, box_min_y_o, box_min_x_o};
      got.hi   = {box_max_z_o, box_max_y_o, box_max_x_o};
      got.last = last_o;
      board.check_box(got);
    end
  end

  function automatic longint rand_span(longint span);
    longint unsigned r;
    r = {$urandom, $urandom};
    return longint'(r % longint'(span + 1));
  endfunction

  function automatic lmws_pkg::coord_t face(int ax, bit hi_side, longint off);
    return lmws_pkg::coord_t'(board.clamp32(
        (hi_side ? board.cube_hi[ax] : board.cube_lo[ax]) + off));
  endfunction

  function automatic lmws_pkg::coord_t mid(int ax);
    return lmws_pkg::coord_t'(board.clamp32((board.cube_lo[ax] + board.cube_hi[ax]) >>> 1));
  endfunction

  function automatic lmws_pkg::coord_t aim(int ax, bit calm);
    longint th;
    longint off;
    int     mode;
    th   = board.near_limit();
    mode = calm ? 11 : $urandom_range(0, 11);
    off  = rand_span(th);
    if ($urandom_range(0, 1)) off = -off;
    case (mode)
      0: begin
        return lmws_pkg::coord_t'($urandom);
      end
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      2, 3, 4: begin
        return face(ax, 1'b0, off);
      end
      5, 6, 7: begin
        return face(ax, 1'b1, off);
      end
      8, 9: begin
        case ($urandom_range(0, 3))
          0: off = th;
          1: off = -th;
          2: off = th + 1;
          default: off = -(th + 1);
        endcase
        return face(ax, mode == 9, off);
      end
      default: begin
        return lmws_pkg::coord_t'(board.clamp32(
            longint'(mid(ax)) + $signed($urandom_range(0, 2000)) - 1000));
      end
    endcase
  endfunction

  task automatic send_pos(lmws_pkg::coord_t x, lmws_pkg::coord_t y, lmws_pkg::coord_t z);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i    <= x;
    pos_y_i    <= y;
    pos_z_i    <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_position(x, y, z);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [lmws_pkg::IdxW-1:0] idx, logic [lmws_pkg::EdgeW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_reg(idx, value);
    // The block recomputes its threshold and move distance after each write.
    repeat (RecalcGap) @(negedge clk_i);
  endtask

  task automatic apply_setting(logic [lmws_pkg::EdgeW-1:0] len,
                               logic [lmws_pkg::EdgeW-1:0] range,
                               logic [lmws_pkg::FactW-1:0] factor);
    drain();
    write_reg(lmws_pkg::RegEdge, len);
    write_reg(lmws_pkg::RegRange, range);
    write_reg(lmws_pkg::RegFactor, lmws_pkg::EdgeW'(factor));
    settings++;
  endtask

  task automatic run_random(int count, bit idle_allowed, bit hold_midway);
    bit calm;
    int k;
    for (k = 0; k < count; k++) begin
      if (k % 40 == 20) gaps_on = 1'b0;
      else if (k % 40 == 0) gaps_on = idle_allowed;
      if (hold_midway && k == count / 2) drain();
      calm = ($urandom_range(0, 7) == 0);
      send_pos(aim(0, calm), aim(1, calm), aim(2, calm));
    end
  endtask

  task automatic at_faces(bit hi_side, longint off);
    send_pos(face(0, hi_side, off), face(1, hi_side, off), face(2, hi_side, off));
  endtask

  initial begin
    int k;
    board       = new();
    settings    = 1;
    gaps_on     = 1'b1;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = lmws_pkg::RegEdge;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    pos_x_i     = '0;
    pos_y_i     = '0;
    pos_z_i     = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_pos(0, 0, 0);
    send_pos(mid(0), mid(1), mid(2));
    send_pos(face(0, 1'b0, board.near_limit()), mid(1), mid(2));
    send_pos(face(0, 1'b0, -(board.near_limit() + 1)), mid(1), mid(2));
    send_pos(mid(0), face(1, 1'b1, -board.near_limit()), mid(2));
    send_pos(mid(0), mid(1), face(2, 1'b1, board.near_limit() + 1));
    at_faces(1'b0, 0);
    at_faces(1'b1, 0);
    send_pos(32'sh7fff_ffff, 32'sh8000_0000, 0);
    send_pos(-1, 32'sh7fff_ffff, 32'sh8000_0000);
    run_random(80, 1'b1, 1'b1);

    apply_setting(31'h7fff_ffff, 31'h7fff_ffff, 16'hffff);
    send_pos(0, 0, 0);
    send_pos(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_pos(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    run_random(40, 1'b1, 1'b0);

    apply_setting('0, '0, '0);
    at_faces(1'b0, 0);
    at_faces(1'b1, 0);
    run_random(40, 1'b1, 1'b0);

    // Small cube with a low factor: the move distance comes out negative.
    apply_setting(31'd655360, 31'd6553600, 16'd128);
    at_faces(1'b0, 0);
    at_faces(1'b1, 0);
    run_random(60, 1'b1, 1'b0);

    for (k = 0; k < 4; k++) begin
      if (k == 3) begin
        apply_setting(lmws_pkg::EdgeW'($urandom), lmws_pkg::EdgeW'($urandom),
                      lmws_pkg::FactW'($urandom));
      end else begin
        apply_setting(lmws_pkg::EdgeW'({$urandom_range(0, 2000), 16'($urandom)}),
                      lmws_pkg::EdgeW'({$urandom_range(0, 300), 16'($urandom)}),
                      lmws_pkg::FactW'($urandom_range(0, 1023)));
      end
      run_random(50, 1'b1, 1'b0);
    end

    apply_setting(lmws_pkg::EdgeReset, lmws_pkg::RangeReset, lmws_pkg::FactorReset);
    gaps_on = 1'b0;
    run_random(60, 1'b0, 1'b0);

    drain();
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d positions under %0d register settings.", board.positions,
             settings);
    $display("Checked %0d removal slab beats and %0d cube beats, %0d mismatches.",
             board.slabs_seen, board.cubes_seen, board.errors);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
